// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
// Each module that uses them has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define BSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Expression must never be true outside reset
`define BSFD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsfd_pkg.sv =====
package bsfd_pkg;

    // Largest payload length accepted in the length field (bytes)
    localparam int MAX_FRAME_BYTES_DEF = 256;

    // Entries in the event queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_PATTERN   = 2'd0;
    localparam logic [1:0] CFG_SYNC_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_FRAME_LIMIT    = 2'd2;

    // Event kinds
    localparam logic [1:0] EVT_SYNC    = 2'd0;
    localparam logic [1:0] EVT_PAYLOAD = 2'd1;
    localparam logic [1:0] EVT_GOOD    = 2'd2;
    localparam logic [1:0] EVT_BAD     = 2'd3;

    // One result event
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  byte_value;
        logic [15:0] frame_length;
        logic [7:0]  expected_sum;
        logic        length_rejected;
        logic        halted_now;
    } bsfd_event_t;

endpackage

// ===== hw/rtl/bit_serial_frame_deframer.sv =====
// Channel    | Dir | Payload
// -----------+-----+----------------------------------------------------------
// s_*        | in  | tdata: rx_bit_value [0], zero [7:1]
// m_*        | out | tdata: byte, length, sum, rejected, halted; tuser: kind
// cfg_*      | in  | register write: index 0 pattern, 1 tolerance, 2 limit
//
// One received bit is accepted per cycle; the event a bit causes passes from
// the front decode into the queue, then into the output register.
// The front stalls only when the four-entry event queue is full.
// Reset is synchronous, active low; no clearing pass is needed after it.
// After the frame limit is reached, bits are still accepted but discarded.
module bit_serial_frame_deframer import bsfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input bits
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] rx_bit_value
    // result events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] byte_value, [23:8] frame_length,
                                   // [31:24] expected_sum, [32] length_rejected,
                                   // [33] halted_now
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    logic        evt_valid;
    bsfd_event_t evt;
    logic        q_ready;
    logic        q_pop;
    logic        head_valid;
    bsfd_event_t head_evt;

    assign s_tready = q_ready;

    // front: bit decode and frame sequencing
    bsfd_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_bit    (s_tdata[0]),
        .in_ready  (q_ready),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // event queue
    bsfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (evt_valid),
        .push_evt   (evt),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_evt   (head_evt)
    );

    // back: output register
    bsfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_evt   (head_evt),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hw/rtl/bsfd_front.sv =====
module bsfd_front import bsfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_bit,
    input  logic        in_ready,
    output logic        evt_valid,
    output bsfd_event_t evt
);

    `include "assert_macros.svh"

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CHECK   = 2'd3;

    localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME_BYTES);

    // configuration registers
    logic [31:0] pattern_reg;
    logic [5:0]  tol_reg;
    logic [31:0] limit_reg;

    // deframer state
    logic [1:0]  phase_reg,   phase_next;
    logic [31:0] win_reg,     win_next;
    logic [15:0] len_reg,     len_next;
    logic [3:0]  fcnt_reg,    fcnt_next;
    logic [2:0]  bitcnt_reg,  bitcnt_next;
    logic [15:0] bytecnt_reg, bytecnt_next;
    logic [7:0]  asm_reg,     asm_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [7:0]  chk_reg,     chk_next;
    logic [31:0] good_reg,    good_next;
    logic        halted_reg,  halted_next;

    logic        accept;
    logic [31:0] win_shift;
    logic [31:0] diff;
    logic [2:0]  nib_cnt [8];
    logic [5:0]  ham_dist;
    logic [15:0] len_shift;
    logic [7:0]  asm_shift;
    logic [7:0]  chk_shift;
    logic [7:0]  xor_upd;
    logic [15:0] bytecnt_inc;
    logic [31:0] good_inc;

    assign accept = in_valid & in_ready;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            tol_reg     <= '0;
            limit_reg   <= 32'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SYNC_PATTERN:   pattern_reg <= cfg_data;
                CFG_SYNC_TOLERANCE: tol_reg     <= cfg_data[5:0];
                CFG_FRAME_LIMIT:    limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // shifted field values and Hamming distance of the new window
    assign win_shift   = {win_reg[30:0], in_bit};
    assign len_shift   = {len_reg[14:0], in_bit};
    assign asm_shift   = {asm_reg[6:0], in_bit};
    assign chk_shift   = {chk_reg[6:0], in_bit};
    assign xor_upd     = xor_reg ^ asm_shift;
    assign bytecnt_inc = bytecnt_reg + 16'd1;
    assign good_inc    = (good_reg == '1) ? good_reg : good_reg + 32'd1;
    assign diff        = win_shift ^ pattern_reg;

    always_comb begin
        ham_dist = '0;
        for (int i = 0; i < 8; i++) begin
            nib_cnt[i] = 3'(diff[4*i]) + 3'(diff[4*i+1])
                       + 3'(diff[4*i+2]) + 3'(diff[4*i+3]);
        end
        for (int i = 0; i < 8; i++) begin
            ham_dist = ham_dist + 6'(nib_cnt[i]);
        end
    end

    // phase sequencing and event generation
    always_comb begin
        phase_next   = phase_reg;
        win_next     = win_reg;
        len_next     = len_reg;
        fcnt_next    = fcnt_reg;
        bitcnt_next  = bitcnt_reg;
        bytecnt_next = bytecnt_reg;
        asm_next     = asm_reg;
        xor_next     = xor_reg;
        chk_next     = chk_reg;
        good_next    = good_reg;
        halted_next  = halted_reg;
        evt_valid    = 1'b0;
        evt          = '0;

        if (accept && !halted_reg) begin
            case (phase_reg)
                PH_SEARCH: begin
                    win_next = win_shift;
                    if (ham_dist <= tol_reg) begin
                        phase_next   = PH_LENGTH;
                        len_next     = '0;
                        fcnt_next    = '0;
                        bitcnt_next  = '0;
                        bytecnt_next = '0;
                        asm_next     = '0;
                        xor_next     = '0;
                        chk_next     = '0;
                        evt_valid    = 1'b1;
                        evt.event_kind = EVT_SYNC;
                    end
                end
                PH_LENGTH: begin
                    len_next  = len_shift;
                    fcnt_next = fcnt_reg + 4'd1;
                    if (fcnt_reg == 4'd15) begin
                        fcnt_next = '0;
                        if (len_shift > LEN_MAX) begin
                            // oversize length: report and search again
                            phase_next = PH_SEARCH;
                            win_next   = '0;
                            evt_valid  = 1'b1;
                            evt.event_kind      = EVT_BAD;
                            evt.frame_length    = len_shift;
                            evt.length_rejected = 1'b1;
                        end else if (len_shift == '0) begin
                            phase_next = PH_CHECK;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    asm_next    = asm_shift;
                    bitcnt_next = bitcnt_reg + 3'd1;
                    if (bitcnt_reg == 3'd7) begin
                        asm_next     = '0;
                        xor_next     = xor_upd;
                        bytecnt_next = bytecnt_inc;
                        if (bytecnt_inc == len_reg) begin
                            phase_next = PH_CHECK;
                            fcnt_next  = '0;
                            chk_next   = '0;
                        end
                        evt_valid = 1'b1;
                        evt.event_kind   = EVT_PAYLOAD;
                        evt.byte_value   = asm_shift;
                        evt.frame_length = len_reg;
                        evt.expected_sum = xor_upd;
                    end
                end
                PH_CHECK: begin
                    chk_next  = chk_shift;
                    fcnt_next = fcnt_reg + 4'd1;
                    if (fcnt_reg == 4'd7) begin
                        fcnt_next  = '0;
                        phase_next = PH_SEARCH;
                        win_next   = '0;
                        evt_valid  = 1'b1;
                        evt.byte_value   = chk_shift;
                        evt.frame_length = len_reg;
                        evt.expected_sum = xor_reg;
                        if (chk_shift == xor_reg) begin
                            evt.event_kind = EVT_GOOD;
                            good_next      = good_inc;
                            if (limit_reg != '0 && good_inc >= limit_reg) begin
                                halted_next    = 1'b1;
                                evt.halted_now = 1'b1;
                            end
                        end else begin
                            evt.event_kind = EVT_BAD;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEARCH;
            win_reg     <= '0;
            len_reg     <= '0;
            fcnt_reg    <= '0;
            bitcnt_reg  <= '0;
            bytecnt_reg <= '0;
            asm_reg     <= '0;
            xor_reg     <= '0;
            chk_reg     <= '0;
            good_reg    <= '0;
            halted_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            win_reg     <= win_next;
            len_reg     <= len_next;
            fcnt_reg    <= fcnt_next;
            bitcnt_reg  <= bitcnt_next;
            bytecnt_reg <= bytecnt_next;
            asm_reg     <= asm_next;
            xor_reg     <= xor_next;
            chk_reg     <= chk_next;
            good_reg    <= good_next;
            halted_reg  <= halted_next;
        end
    end

    // once halted, no further events
    `BSFD_ASSERT(a_halt_silent, halted_reg |-> !evt_valid, "event after halt")
    // sync events only come out of the search phase
    `BSFD_ASSERT(a_sync_from_search, (evt_valid && evt.event_kind == EVT_SYNC) |-> (phase_reg == PH_SEARCH), "sync event outside search")
    // length rejection is always a bad-frame event
    `BSFD_ASSERT_NEVER(a_rej_kind, evt_valid && evt.length_rejected && evt.event_kind != EVT_BAD, "rejection with wrong kind")

endmodule

// ===== hw/rtl/bsfd_queue.sv =====
module bsfd_queue import bsfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bsfd_event_t push_evt,
    output logic        push_ready,
    input  logic        pop,
    output logic        head_valid,
    output bsfd_event_t head_evt
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    bsfd_event_t     mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_evt   = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & head_valid;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // event storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

    // the front must stall rather than push into a full queue
    `BSFD_ASSERT(a_no_overflow, push |-> push_ready, "push into full queue")
    // a lone push grows the occupancy by exactly one
    `BSFD_ASSERT(a_push_count, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CW'(1)), "occupancy mismatch")

endmodule

// ===== hw/rtl/bsfd_back.sv =====
module bsfd_back import bsfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  bsfd_event_t head_evt,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser
);

    bsfd_event_t out_reg;
    logic        valid_reg, valid_next;

    // load a new event whenever the output register is free or draining
    assign pop        = head_valid & (~valid_reg | m_tready);
    assign valid_next = pop | (valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head_evt;
        end
    end

    // pack the output transaction
    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'b0, out_reg.halted_now, out_reg.length_rejected,
                       out_reg.expected_sum, out_reg.frame_length, out_reg.byte_value};

endmodule
